// ===== design/mwps_pkg.sv =====
// Package for the masked word pattern scanner.
// Holds the command type passed from the front through the queue to the back.
// No dependencies.
package mwps_pkg;

    localparam int WORD_W      = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int CFG_W       = 5;
    localparam int RESULT_W    = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_SCAN = 1'b1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SCAN = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [7:0]              data;
        logic                    last;
        logic [ENTRY_IDX_W-1:0]  index;
        logic [WORD_W-1:0]       pattern;
        logic [WORD_W-1:0]       mask;
    } cmd_t;

endpackage

// ===== design/mwps_front.sv =====
// Front of the scanner: decodes input transactions into commands.
// Loads that address a missing table entry are dropped here.
// Depends on mwps_pkg.
module mwps_front #(
    parameter int MAX_WORDS = 16
) (
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    input  logic [mwps_pkg::ENTRY_IDX_W-1:0]    entry_index,
    input  logic [mwps_pkg::WORD_W-1:0]         entry_pattern,
    input  logic [mwps_pkg::WORD_W-1:0]         entry_mask,
    output logic                                push_valid,
    output mwps_pkg::cmd_t                      push_cmd,
    input  logic                                push_ready
);

    logic keep;

    always_comb
    begin
        push_cmd.data    = data_byte;
        push_cmd.last    = last_byte;
        push_cmd.index   = entry_index;
        push_cmd.pattern = entry_pattern;
        push_cmd.mask    = entry_mask;
        unique case (action)
            mwps_pkg::ACTION_LOAD:
            begin
                push_cmd.kind = mwps_pkg::CMD_LOAD;
                keep          = (32'(entry_index) < MAX_WORDS);
            end
            mwps_pkg::ACTION_SCAN:
            begin
                push_cmd.kind = mwps_pkg::CMD_SCAN;
                keep          = 1'b1;
            end
            default:
            begin
                push_cmd.kind = mwps_pkg::CMD_SCAN;
                keep          = 1'b1;
            end
        endcase
    end

    // A dropped load is still accepted; it just never enters the queue.
    assign in_ready   = push_ready;
    assign push_valid = in_valid && keep;

endmodule

// ===== design/mwps_queue.sv =====
// Short command queue between the front and the back of the scanner.
// Register-based FIFO of mwps_pkg::cmd_t entries.
// Depends on mwps_pkg.
module mwps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  mwps_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    output logic            pop_valid,
    output mwps_pkg::cmd_t  pop_cmd,
    input  logic            pop_ready
);

    mwps_pkg::cmd_t                 entry_reg [mwps_pkg::QUEUE_DEPTH];
    logic [mwps_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mwps_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mwps_pkg::QCNT_W-1:0]    count_reg;
    logic [mwps_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != mwps_pkg::QCNT_W'(mwps_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mwps_pkg::QCNT_W'(mwps_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds its depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower the queue count");
`endif

endmodule

// ===== design/mwps_back.sv =====
// Back of the scanner: table writes, byte window, parallel masked compare
// and the result register. Three steps: execute, compare, decide.
// Depends on mwps_pkg.
module mwps_back #(
    parameter int MAX_WORDS   = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mwps_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            pop_valid,
    input  mwps_pkg::cmd_t                  pop_cmd,
    output logic                            pop_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [mwps_pkg::RESULT_W-1:0]   match_offset
);

    localparam int WIN_BYTES = 4 * MAX_WORDS;
    localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WORDS + 1);
    localparam int SPAN_W    = WCNT_W + 2;
    localparam int CMP_W     = (OFFSET_BITS > SPAN_W) ? OFFSET_BITS : SPAN_W;

    logic [mwps_pkg::CFG_W-1:0]     pattern_words_reg;
    logic [WCNT_W-1:0]              words;

    logic [7:0]                     win_reg [WIN_BYTES];
    logic [mwps_pkg::WORD_W-1:0]    win_word [MAX_WORDS];
    logic [mwps_pkg::WORD_W-1:0]    exp_reg [MAX_WORDS];
    logic [mwps_pkg::WORD_W-1:0]    mask_reg [MAX_WORDS];
    logic [OFFSET_BITS-1:0]         seen_reg;
    logic [OFFSET_BITS-1:0]         seen_next;
    logic [OFFSET_BITS-1:0]         seen_inc;

    logic                           b1_valid_reg;
    logic                           b1_last_reg;
    logic [OFFSET_BITS-1:0]         b1_seen_reg;

    logic                           b2_valid_reg;
    logic                           b2_last_reg;
    logic                           b2_elig_reg;
    logic [MAX_WORDS-1:0]           b2_mis_reg;
    logic [mwps_pkg::RESULT_W-1:0]  b2_offset_reg;

    logic [MAX_WORDS-1:0]           mis_next;
    logic [CMP_W-1:0]               seen_ext;
    logic [CMP_W-1:0]               span_ext;
    logic [CMP_W-1:0]               diff;
    logic                           elig_next;

    logic                           reported_reg;
    logic                           reported_next;
    logic                           out_valid_reg;
    logic                           found_reg;
    logic [mwps_pkg::RESULT_W-1:0]  offset_reg;

    logic                           en;
    logic                           do_pop;
    logic                           do_scan;
    logic                           do_load;
    logic                           hit;
    logic                           emit;

    // The whole back advances together, and only when the result slot is free.
    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;
    assign do_pop    = pop_valid && en;
    assign do_scan   = do_pop && (pop_cmd.kind == mwps_pkg::CMD_SCAN);
    assign do_load   = do_pop && (pop_cmd.kind == mwps_pkg::CMD_LOAD);

    always_comb
    begin
        if (32'(pattern_words_reg) > MAX_WORDS)
        begin
            words = WCNT_W'(MAX_WORDS);
        end
        else
        begin
            words = WCNT_W'(pattern_words_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_words_reg <= mwps_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            pattern_words_reg <= cfg_wdata;
        end
    end

    // Execute step: table writes, window shift and the saturating byte count.
    assign seen_inc  = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign seen_next = pop_cmd.last ? '0 : seen_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            b1_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            b1_valid_reg <= do_scan;
            if (do_scan)
            begin
                seen_reg   <= seen_next;
                win_reg[0] <= pop_cmd.data;
                for (int i = 1; i < WIN_BYTES; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            exp_reg[WIDX_W'(pop_cmd.index)]  <= pop_cmd.pattern;
            mask_reg[WIDX_W'(pop_cmd.index)] <= pop_cmd.mask;
        end
        if (en && do_scan)
        begin
            b1_last_reg <= pop_cmd.last;
            b1_seen_reg <= seen_inc;
        end
    end

    // Compare step. Window bytes outside the current stream never reach a
    // compare because the byte count gates eligibility, so they need no clear.
    for (genvar k = 0; k < MAX_WORDS; k++)
    begin : g_word
        // The oldest byte of each word is its least significant byte.
        assign win_word[k] = {win_reg[4*k], win_reg[4*k+1], win_reg[4*k+2], win_reg[4*k+3]};
    end

    for (genvar j = 0; j < MAX_WORDS; j++)
    begin : g_entry
        logic [WIDX_W-1:0] sel;
        // Entry j lines up with the window word that is words-1-j words old.
        assign sel = WIDX_W'(words - WCNT_W'(j + 1));
        assign mis_next[j] = (WCNT_W'(j) < words) &&
                             (|((win_word[sel] ^ exp_reg[j]) & ~mask_reg[j]));
    end

    assign seen_ext  = CMP_W'(b1_seen_reg);
    assign span_ext  = CMP_W'({words, 2'b00});
    assign diff      = seen_ext - span_ext;
    assign elig_next = (words != '0) && (seen_ext >= span_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && b1_valid_reg)
        begin
            b2_last_reg   <= b1_last_reg;
            b2_elig_reg   <= elig_next;
            b2_mis_reg    <= mis_next;
            b2_offset_reg <= mwps_pkg::RESULT_W'(diff);
        end
    end

    // Decide step: first match of a stream, or not found on its last byte.
    assign hit  = b2_elig_reg && !(|b2_mis_reg);
    assign emit = b2_valid_reg && !reported_reg && (hit || b2_last_reg);

    always_comb
    begin
        reported_next = reported_reg;
        if (b2_valid_reg)
        begin
            if (b2_last_reg)
            begin
                reported_next = 1'b0;
            end
            else if (emit)
            begin
                reported_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            reported_reg  <= reported_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && emit)
        begin
            found_reg  <= hit;
            offset_reg <= hit ? b2_offset_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

`ifndef SYNTHESIS
    a_scan_counted: assert property (@(posedge clk) disable iff (!rst_n)
        b1_valid_reg |-> (b1_seen_reg != '0))
        else $error("scan reached compare with a zero byte count");
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (offset_reg == '0))
        else $error("not-found result carries a nonzero offset");
    a_match_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (en && emit && !b2_last_reg) |=> reported_reg)
        else $error("match result did not mark the stream as reported");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (en && b2_valid_reg && b2_last_reg) |=> !reported_reg)
        else $error("end of stream did not clear the reported flag");
`endif

endmodule

// ===== design/masked_word_pattern_scanner_top.sv =====
// Top level of the masked word pattern scanner.
// Instantiates mwps_front, mwps_queue and mwps_back; depends on mwps_pkg.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    action, data_byte, last_byte, entry_index,
//                                   entry_pattern, entry_mask
//  result    out_valid / out_ready  found, match_offset
//  config    cfg_we                 cfg_wdata (pattern_words)
//
// Sustained rate is one transaction per cycle while no result stalls; every
// table compare runs in parallel in the compare step, fed by the shifting
// byte window. A result shows on out_valid once the scan byte that causes it
// has been accepted and passed the queue, execute, compare and decide steps.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds the whole back; the queue absorbs four commands
// before in_ready falls.
module masked_word_pattern_scanner_top #(
    parameter int MAX_WORDS   = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mwps_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    input  logic [mwps_pkg::ENTRY_IDX_W-1:0]    entry_index,
    input  logic [mwps_pkg::WORD_W-1:0]         entry_pattern,
    input  logic [mwps_pkg::WORD_W-1:0]         entry_mask,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [mwps_pkg::RESULT_W-1:0]       match_offset
);

    logic           push_valid;
    logic           push_ready;
    mwps_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    mwps_pkg::cmd_t pop_cmd;

    mwps_front #(
        .MAX_WORDS     (MAX_WORDS)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .entry_index   (entry_index),
        .entry_pattern (entry_pattern),
        .entry_mask    (entry_mask),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    mwps_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready),
        .pop_valid     (pop_valid),
        .pop_cmd       (pop_cmd),
        .pop_ready     (pop_ready)
    );

    mwps_back #(
        .MAX_WORDS     (MAX_WORDS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pop_valid     (pop_valid),
        .pop_cmd       (pop_cmd),
        .pop_ready     (pop_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_offset  (match_offset)
    );

endmodule

// ===== dv/tb_masked_word_pattern_scanner_top.sv =====
`timescale 1ns / 1ps
// Testbench for masked_word_pattern_scanner_top: sends table loads and scan bytes,
// predicts every result with its own scanner model and checks each one field by field.
// Depends on mwps_pkg and the design sources.
module tb_masked_word_pattern_scanner_top;

    localparam int MAX_WORDS     = 16;
    localparam int WINDOW_BYTES  = 4 * MAX_WORDS;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 110;
    localparam int PRINT_LIMIT   = 100;

    typedef struct {
        logic                             action;
        logic [7:0]                       data;
        logic                             last;
        logic [mwps_pkg::ENTRY_IDX_W-1:0] index;
        logic [mwps_pkg::WORD_W-1:0]      pattern;
        logic [mwps_pkg::WORD_W-1:0]      mask;
    } scan_item_t;

    typedef struct {
        logic                          found;
        logic [mwps_pkg::RESULT_W-1:0] offset;
    } scan_result_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_we        = 1'b0;
    logic [mwps_pkg::CFG_W-1:0]       cfg_wdata     = '0;
    logic                             in_valid      = 1'b0;
    logic                             action        = mwps_pkg::ACTION_LOAD;
    logic [7:0]                       data_byte     = '0;
    logic                             last_byte     = 1'b0;
    logic [mwps_pkg::ENTRY_IDX_W-1:0] entry_index   = '0;
    logic [mwps_pkg::WORD_W-1:0]      entry_pattern = '0;
    logic [mwps_pkg::WORD_W-1:0]      entry_mask    = '0;
    logic                             out_ready     = 1'b0;
    logic                             in_ready;
    logic                             out_valid;
    logic                             found;
    logic [mwps_pkg::RESULT_W-1:0]    match_offset;

    // Scanner model state.
    logic [7:0]                  model_window [WINDOW_BYTES];
    logic [mwps_pkg::WORD_W-1:0] model_words  [MAX_WORDS];
    logic [mwps_pkg::WORD_W-1:0] model_masks  [MAX_WORDS];
    logic [31:0]                 model_seen;
    logic                        model_reported;
    logic [mwps_pkg::CFG_W-1:0]  model_pw;
    scan_result_t                expected_results [$];

    int items_sent    = 0;
    int found_count   = 0;
    int missing_count = 0;
    int error_count   = 0;
    int send_gap_pct  = 0;
    int ready_gap_pct = 0;

    masked_word_pattern_scanner_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .entry_index   (entry_index),
        .entry_pattern (entry_pattern),
        .entry_mask    (entry_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_offset  (match_offset)
    );

    always #5 clk = ~clk;

    function automatic void clear_stream();
        foreach (model_window[k])
        begin
            model_window[k] = '0;
        end
        model_seen     = '0;
        model_reported = 1'b0;
    endfunction

    function automatic int active_words();
        if (model_pw > MAX_WORDS)
        begin
            return MAX_WORDS;
        end
        return int'(model_pw);
    endfunction

    // The oldest byte of the run is the low byte of table word 0.
    function automatic logic window_matches(input int words);
        logic [mwps_pkg::WORD_W-1:0] w;
        for (int j = 0; j < words; j++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                w[8*b +: 8] = model_window[4*words - 1 - 4*j - b];
            end
            if (((w ^ model_words[j]) & ~model_masks[j]) != '0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_item(input scan_item_t it);
        scan_result_t r;
        int           words;
        if (it.action == mwps_pkg::ACTION_LOAD)
        begin
            if (int'(it.index) < MAX_WORDS)
            begin
                model_words[it.index] = it.pattern;
                model_masks[it.index] = it.mask;
            end
            return;
        end
        for (int k = WINDOW_BYTES - 1; k > 0; k--)
        begin
            model_window[k] = model_window[k-1];
        end
        model_window[0] = it.data;
        if (model_seen != 32'hFFFF_FFFF)
        begin
            model_seen++;
        end
        words = active_words();
        if (!model_reported)
        begin
            if (words != 0 && model_seen >= 32'(4 * words) && window_matches(words))
            begin
                r.found        = 1'b1;
                r.offset       = model_seen - 32'(4 * words);
                model_reported = 1'b1;
                expected_results.push_back(r);
            end
            else if (it.last)
            begin
                r.found  = 1'b0;
                r.offset = '0;
                expected_results.push_back(r);
            end
        end
        if (it.last)
        begin
            clear_stream();
        end
    endfunction

    function automatic logic [mwps_pkg::WORD_W-1:0] pick_mask();
        case ($urandom_range(7))
            0, 1:    return '0;
            2, 3:    return $urandom & $urandom;
            4, 5:    return $urandom & $urandom & $urandom;
            6:       return $urandom;
            default: return '1;
        endcase
    endfunction

    function automatic scan_item_t scan_byte(input logic [7:0] d, input logic l);
        scan_item_t it;
        it.action  = mwps_pkg::ACTION_SCAN;
        it.data    = d;
        it.last    = l;
        it.index   = mwps_pkg::ENTRY_IDX_W'($urandom);
        it.pattern = $urandom;
        it.mask    = $urandom;
        return it;
    endfunction

    function automatic scan_item_t load_entry(input logic [mwps_pkg::ENTRY_IDX_W-1:0] idx,
                                              input logic [mwps_pkg::WORD_W-1:0] pat,
                                              input logic [mwps_pkg::WORD_W-1:0] mask);
        scan_item_t it;
        it.action  = mwps_pkg::ACTION_LOAD;
        it.data    = 8'($urandom);
        it.last    = 1'($urandom);
        it.index   = idx;
        it.pattern = pat;
        it.mask    = mask;
        return it;
    endfunction

    task automatic send_item(input scan_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= it.action;
        data_byte     <= it.data;
        last_byte     <= it.last;
        entry_index   <= it.index;
        entry_pattern <= it.pattern;
        entry_mask    <= it.mask;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_item(it);
        items_sent++;
    endtask

    // The sender holds off until every pending result is in, then lets the pipeline empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pattern_words(input logic [mwps_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        model_pw  = value;
        @(posedge clk);
    endtask

    // One stream: random lead-in, often a planted run that fits the table, random tail.
    task automatic run_stream();
        logic [7:0]                  body [$];
        logic [mwps_pkg::WORD_W-1:0] w;
        int                          words;
        int                          lead_len;
        int                          pos;
        bit                          plant;
        words = active_words();
        repeat ($urandom_range(2))
        begin
            send_item(load_entry(mwps_pkg::ENTRY_IDX_W'($urandom), $urandom, pick_mask()));
        end
        plant    = (words != 0) && ($urandom_range(99) < 80);
        lead_len = $urandom_range(6);
        repeat (lead_len) body.push_back(8'($urandom));
        if (plant)
        begin
            for (int j = 0; j < words; j++)
            begin
                w = (model_words[j] & ~model_masks[j]) | ($urandom & model_masks[j]);
                for (int b = 0; b < 4; b++)
                begin
                    body.push_back(w[8*b +: 8]);
                end
            end
            // A broken run: one bit flipped somewhere inside it.
            if ($urandom_range(99) < 20)
            begin
                pos       = lead_len + $urandom_range(4 * words - 1);
                body[pos] = body[pos] ^ 8'(1 << $urandom_range(7));
            end
        end
        repeat ($urandom_range(3)) body.push_back(8'($urandom));
        if (body.size() == 0)
        begin
            body.push_back(8'($urandom));
        end
        for (int i = 0; i < body.size(); i++)
        begin
            if ($urandom_range(99) < 5)
            begin
                send_item(load_entry(mwps_pkg::ENTRY_IDX_W'($urandom), $urandom, pick_mask()));
            end
            send_item(scan_byte(body[i], i == body.size() - 1));
        end
    endtask

    task automatic test_table_load();
        send_item(load_entry(mwps_pkg::ENTRY_IDX_W'(0), 32'hFFFF_FFFF, 32'h0000_0000));
        for (int i = 1; i < MAX_WORDS - 1; i++)
        begin
            send_item(load_entry(mwps_pkg::ENTRY_IDX_W'(i), $urandom, pick_mask()));
        end
        send_item(load_entry(mwps_pkg::ENTRY_IDX_W'(MAX_WORDS - 1),
                             32'h0000_0000, 32'hFFFF_FFFF));
    endtask

    // Reset value of pattern_words is one word; entry 0 wants all ones.
    task automatic test_match_on_last_byte();
        for (int i = 0; i < 4; i++)
        begin
            send_item(scan_byte(8'hFF, i == 3));
        end
    endtask

    // The previous stream's bytes must be gone, and one byte is too few to compare.
    task automatic test_stream_too_short();
        send_item(scan_byte(8'hFF, 1'b1));
    endtask

    task automatic test_bytes_after_match();
        for (int i = 0; i < 5; i++)
        begin
            send_item(scan_byte(8'hFF, i == 4));
        end
        wait_idle();
    endtask

    task automatic test_random_scans(input int send_pct, input int ready_pct,
                                     input logic [mwps_pkg::CFG_W-1:0] pw_a, pw_b, pw_c);
        logic [mwps_pkg::CFG_W-1:0] settings [3];
        int                         start;
        settings      = '{pw_a, pw_b, pw_c};
        send_gap_pct  = send_pct;
        ready_gap_pct = ready_pct;
        foreach (settings[s])
        begin
            write_pattern_words(settings[s]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                run_stream();
            end
            wait_idle();
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        scan_result_t want;
        out_ready <= ($urandom_range(99) >= ready_gap_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_LIMIT)
                begin
                    $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d",
                             $time, found, match_offset);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (found !== want.found)
                begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                    begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, found);
                    end
                end
                if (match_offset !== want.offset)
                begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                    begin
                        $display("%0t: match_offset expected %0d actual %0d",
                                 $time, want.offset, match_offset);
                    end
                end
                if (want.found)
                begin
                    found_count++;
                end
                else
                begin
                    missing_count++;
                end
            end
        end
    end

    initial
    begin
        model_pw = mwps_pkg::CFG_W'(1);
        clear_stream();
        foreach (model_words[i])
        begin
            model_words[i] = '0;
            model_masks[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_match_on_last_byte();
        test_stream_too_short();
        test_bytes_after_match();
        test_random_scans(28, 64, mwps_pkg::CFG_W'(2), mwps_pkg::CFG_W'(0), mwps_pkg::CFG_W'(16));
        test_random_scans(64, 28, mwps_pkg::CFG_W'(3), mwps_pkg::CFG_W'(31), mwps_pkg::CFG_W'(1));
        test_random_scans(0, 0, mwps_pkg::CFG_W'(4), mwps_pkg::CFG_W'(1), mwps_pkg::CFG_W'(2));

        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results expected but never received",
                     $time, expected_results.size());
        end
        $display("Covered %0d transactions: %0d found and %0d not-found results,",
                 items_sent, found_count, missing_count);
        $display("pattern_words from 0 to 31, mid-stream table loads and stalls on both sides.");
        if (error_count == 0)
        begin
            $display("masked_word_pattern_scanner_top: match");
        end
        else
        begin
            $display("masked_word_pattern_scanner_top: mismatch");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("masked_word_pattern_scanner_top: mismatch");
        $finish;
    end

endmodule
